>>> hw/rtl/limb_stream_divide_by_invariant_defines.svh
// ----------------------------------------------------------------------------
// limb_stream_divide_by_invariant_defines
// assertion macros shared by the checker of the limb divider
// ----------------------------------------------------------------------------
`ifndef LIMB_STREAM_DIVIDE_BY_INVARIANT_DEFINES_SVH
`define LIMB_STREAM_DIVIDE_BY_INVARIANT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lsd same-cycle check failed");

// next-cycle implication, disabled during reset
`define LSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lsd next-cycle check failed");

`endif

>>> hw/rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// types and constants of the limb stream divider
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

    localparam int LIMB_WIDTH = 64;
    localparam int HALF_WIDTH = LIMB_WIDTH / 2;
    localparam int CNT_W      = $clog2(LIMB_WIDTH);

    localparam logic [CNT_W-1:0] RECIP_LAST = CNT_W'(LIMB_WIDTH - 1);
    localparam logic [CNT_W-1:0] MULA_LAST  = CNT_W'(3);
    localparam logic [CNT_W-1:0] MULB_LAST  = CNT_W'(2);

    localparam logic [LIMB_WIDTH-1:0] RESET_DN    = {1'b1, {(LIMB_WIDTH-1){1'b0}}};
    localparam logic [LIMB_WIDTH-1:0] RESET_RECIP = {LIMB_WIDTH{1'b1}};
    localparam logic [CNT_W-1:0]      RESET_SHIFT = CNT_W'(LIMB_WIDTH - 1);

    typedef struct packed {
        logic [63:0] dividend_limb;
        logic        last_limb;
    } in_item_t;

    typedef struct packed {
        logic [63:0] quotient_limb;
        logic [63:0] remainder;
        logic        is_last;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NORM_STEP,
        OP_RECIP_INIT,
        OP_RECIP_STEP,
        OP_LOAD,
        OP_MUL_A,
        OP_QEST,
        OP_MUL_B,
        OP_FIX1,
        OP_FIX2,
        OP_FIX3,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_load;
        logic norm_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsd_ctrl.sv
// ----------------------------------------------------------------------------
// lsd_ctrl
// sequencer for divisor derivation and the per-limb 2/1 division step
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ctrl
    import lsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_NORM  = 10'b00_0000_0010,
        ST_RECIP = 10'b00_0000_0100,
        ST_MULA  = 10'b00_0000_1000,
        ST_QEST  = 10'b00_0001_0000,
        ST_MULB  = 10'b00_0010_0000,
        ST_FIX1  = 10'b00_0100_0000,
        ST_FIX2  = 10'b00_1000_0000,
        ST_FIX3  = 10'b01_0000_0000,
        ST_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_ready  = (state_reg == ST_IDLE) && !status.cfg_load;
    assign cmd.step = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        if (status.cfg_load) begin
            // a new divisor restarts derivation
            state_next = ST_NORM;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd.op     = OP_LOAD;
                        cnt_next   = '0;
                        state_next = ST_MULA;
                    end
                end
                ST_NORM: begin
                    if (status.norm_done) begin
                        cmd.op     = OP_RECIP_INIT;
                        cnt_next   = '0;
                        state_next = ST_RECIP;
                    end else begin
                        cmd.op = OP_NORM_STEP;
                    end
                end
                ST_RECIP: begin
                    cmd.op   = OP_RECIP_STEP;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == RECIP_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_MULA: begin
                    cmd.op = OP_MUL_A;
                    if (cnt_reg == MULA_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_QEST;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_QEST: begin
                    cmd.op     = OP_QEST;
                    cnt_next   = '0;
                    state_next = ST_MULB;
                end
                ST_MULB: begin
                    cmd.op = OP_MUL_B;
                    if (cnt_reg == MULB_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_FIX1;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_FIX1: begin
                    cmd.op     = OP_FIX1;
                    state_next = ST_FIX2;
                end
                ST_FIX2: begin
                    cmd.op     = OP_FIX2;
                    state_next = ST_FIX3;
                end
                ST_FIX3: begin
                    cmd.op     = OP_FIX3;
                    state_next = ST_EMIT;
                end
                ST_EMIT: begin
                    if (status.out_free) begin
                        cmd.op     = OP_EMIT;
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lsd_dpath.sv
// ----------------------------------------------------------------------------
// lsd_dpath
// divisor derivation, shared 32x32 multiplier and the 2/1 step datapath
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_dpath
    import lsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  in_item_t        s_data,
    output out_item_t       m_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  dp_cmd_t         cmd,
    output dp_status_t      status
);

    logic [LIMB_WIDTH-1:0]   dn_reg, recip_reg, rr_reg;
    logic [CNT_W-1:0]        shift_reg;
    logic [LIMB_WIDTH-1:0]   wrem_reg, wquo_reg;
    logic [LIMB_WIDTH-1:0]   top_reg, bot_reg, pl_reg, qt_reg, rm_reg;
    logic [2*LIMB_WIDTH-1:0] acc_reg;
    logic                    last_reg;
    out_item_t               m_data_reg;
    logic                    m_valid_reg;

    logic                    cfg_load;
    logic [2*LIMB_WIDTH-1:0] load_wide;
    logic [HALF_WIDTH-1:0]   mul_a, mul_b;
    logic [LIMB_WIDTH-1:0]   prod;
    logic [2*LIMB_WIDTH-1:0] prod_sh;
    logic [LIMB_WIDTH:0]     pl_sum;
    logic [LIMB_WIDTH-1:0]   rs_shift;
    logic                    rs_sub;
    logic [LIMB_WIDTH-1:0]   rem_out;

    assign cfg_load         = cfg_we && (cfg_wdata[LIMB_WIDTH-1:0] != '0);
    assign status.cfg_load  = cfg_load;
    assign status.norm_done = dn_reg[LIMB_WIDTH-1];
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_data           = m_data_reg;
    assign m_valid          = m_valid_reg;

    // remainder and limb shifted together by the normalization shift
    assign load_wide = {rr_reg, s_data.dividend_limb[LIMB_WIDTH-1:0]} << shift_reg;

    // operand select for the shared multiplier
    always_comb begin
        mul_a   = qt_reg[HALF_WIDTH-1:0];
        mul_b   = dn_reg[HALF_WIDTH-1:0];
        prod_sh = '0;
        if (cmd.op == OP_MUL_A) begin
            mul_a = cmd.step[1] ? recip_reg[LIMB_WIDTH-1:HALF_WIDTH]
                                : recip_reg[HALF_WIDTH-1:0];
            mul_b = cmd.step[0] ? top_reg[LIMB_WIDTH-1:HALF_WIDTH]
                                : top_reg[HALF_WIDTH-1:0];
        end else begin
            case (cmd.step[1:0])
                2'd1: begin
                    mul_b = dn_reg[LIMB_WIDTH-1:HALF_WIDTH];
                end
                2'd2: begin
                    mul_a = qt_reg[LIMB_WIDTH-1:HALF_WIDTH];
                end
                default: begin
                end
            endcase
        end
        prod = LIMB_WIDTH'(mul_a) * LIMB_WIDTH'(mul_b);
        if (cmd.op == OP_MUL_A) begin
            case (cmd.step[1:0])
                2'd0:    prod_sh = {{LIMB_WIDTH{1'b0}}, prod};
                2'd3:    prod_sh = {prod, {LIMB_WIDTH{1'b0}}};
                default: prod_sh = {{HALF_WIDTH{1'b0}}, prod, {HALF_WIDTH{1'b0}}};
            endcase
        end else begin
            prod_sh = (cmd.step[1:0] == 2'd0) ? {{LIMB_WIDTH{1'b0}}, prod}
                    : {{HALF_WIDTH{1'b0}}, prod, {HALF_WIDTH{1'b0}}};
        end
    end

    assign pl_sum   = {1'b0, acc_reg[LIMB_WIDTH-1:0]} + {1'b0, bot_reg};
    assign rs_shift = {wrem_reg[LIMB_WIDTH-2:0], 1'b1};
    assign rs_sub   = wrem_reg[LIMB_WIDTH-1] || (rs_shift >= dn_reg);
    assign rem_out  = rm_reg >> shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_reg      <= RESET_DN;
            recip_reg   <= RESET_RECIP;
            shift_reg   <= RESET_SHIFT;
            rr_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (cmd.op != OP_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_load) begin
                dn_reg    <= cfg_wdata[LIMB_WIDTH-1:0];
                shift_reg <= '0;
                rr_reg    <= '0;
            end else begin
                case (cmd.op)
                    OP_NORM_STEP: begin
                        dn_reg    <= dn_reg << 1;
                        shift_reg <= shift_reg + 1'b1;
                    end
                    OP_RECIP_INIT: begin
                        wrem_reg <= ~dn_reg;
                        wquo_reg <= '0;
                    end
                    OP_RECIP_STEP: begin
                        // one restoring division bit per cycle
                        wrem_reg <= rs_sub ? (rs_shift - dn_reg) : rs_shift;
                        wquo_reg <= {wquo_reg[LIMB_WIDTH-2:0], rs_sub};
                        if (cmd.step == RECIP_LAST) begin
                            recip_reg <= {wquo_reg[LIMB_WIDTH-2:0], rs_sub};
                        end
                    end
                    OP_LOAD: begin
                        top_reg  <= load_wide[2*LIMB_WIDTH-1:LIMB_WIDTH];
                        bot_reg  <= load_wide[LIMB_WIDTH-1:0];
                        last_reg <= s_data.last_limb;
                        acc_reg  <= '0;
                    end
                    OP_MUL_A: begin
                        acc_reg <= acc_reg + prod_sh;
                    end
                    OP_QEST: begin
                        pl_reg  <= pl_sum[LIMB_WIDTH-1:0];
                        qt_reg  <= acc_reg[2*LIMB_WIDTH-1:LIMB_WIDTH] + top_reg + 1'b1
                                   + LIMB_WIDTH'(pl_sum[LIMB_WIDTH]);
                        acc_reg <= '0;
                    end
                    OP_MUL_B: begin
                        acc_reg <= {{LIMB_WIDTH{1'b0}},
                                    acc_reg[LIMB_WIDTH-1:0] + prod_sh[LIMB_WIDTH-1:0]};
                    end
                    OP_FIX1: begin
                        rm_reg <= bot_reg - acc_reg[LIMB_WIDTH-1:0];
                    end
                    OP_FIX2: begin
                        if (rm_reg > pl_reg) begin
                            qt_reg <= qt_reg - 1'b1;
                            rm_reg <= rm_reg + dn_reg;
                        end
                    end
                    OP_FIX3: begin
                        if (rm_reg >= dn_reg) begin
                            qt_reg <= qt_reg + 1'b1;
                            rm_reg <= rm_reg - dn_reg;
                        end
                    end
                    OP_EMIT: begin
                        m_data_reg.quotient_limb <= qt_reg;
                        m_data_reg.remainder     <= rem_out;
                        m_data_reg.is_last       <= last_reg;
                        m_valid_reg              <= 1'b1;
                        rr_reg                   <= last_reg ? '0 : rem_out;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/limb_stream_divide_by_invariant.sv
// ----------------------------------------------------------------------------
// limb_stream_divide_by_invariant
// long number divided by a one-limb invariant divisor, limb by limb
// ----------------------------------------------------------------------------
// s_ channel takes dividend words, most significant limb first, last_limb on
// the least significant one. m_ channel returns one word per input word:
// quotient limb, running remainder and is_last.
// cfg_we/cfg_wdata write the divisor; a zero value is dropped. A write clears
// the running remainder, then the block finds the normalization shift (one
// bit a cycle, up to 63 bits, then a setup step) and the reciprocal (one
// restoring division bit a cycle, 64 bits); s_ready stays low meanwhile.
// Each word occupies the block through the load, seven passes through the
// one shared 32x32 multiplier, the quotient estimate, three correction
// steps and the output write, so a new word is accepted only after the last
// one's output write. m_valid and s_ready then rise together. After reset the
// divisor is 1 and the block is ready at once.
// A result waits in the output register while m_ready is low; the next word
// is still accepted and worked on, and stalls only at its own output write.
// ----------------------------------------------------------------------------
`default_nettype none

module limb_stream_divide_by_invariant
    import lsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lsd_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lsd_checker.sv
// ----------------------------------------------------------------------------
// lsd_checker
// port-level checks of the limb divider, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "limb_stream_divide_by_invariant_defines.svh"

module lsd_checker
    import lsd_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic [63:0] cfg_wdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input in_item_t         s_data,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input out_item_t        m_data
);

    // one word in flight at a time
    `LSD_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // a nonzero divisor write starts derivation and blocks input
    `LSD_ASSERT_NEXT(a_cfg_blocks, cfg_we && (cfg_wdata != 64'd0), !s_ready)

    // a stalled result holds
    `LSD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind limb_stream_divide_by_invariant lsd_checker u_lsd_checker (.*);

`default_nettype wire
